// ===== rtl/b2da_pkg.sv =====
// Shared types and constants of the binary to decimal ASCII converter.
package b2da_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_DIGITS_DEF = 10;

    localparam int CFG_DATA_W = 4;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_PAD_ENABLE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_WIDTH  = 1'd1;

    localparam logic       PAD_ENABLE_RST = 1'b1;
    localparam logic [3:0] MIN_WIDTH_RST  = 4'd6;

    localparam logic [5:0] ASCII_ZERO = 6'h30;
    localparam logic [3:0] BCD_FIVE   = 4'd5;
    localparam logic [3:0] BCD_ADJ    = 4'd3;

    typedef struct packed {
        logic load;
        logic conv_shift;
        logic digit_shift;
        logic emit;
        logic last;
    } dp_cmd_t;

    typedef struct packed {
        logic top_nz;
        logic overflow;
    } dp_stat_t;

endpackage

// ===== rtl/b2da_dp.sv =====
// Datapath: double-dabble shift registers and the character output register.
module b2da_dp #(
    parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS-1:0] value,
    input  b2da_pkg::dp_cmd_t     cmd,
    output b2da_pkg::dp_stat_t    stat,
    output logic                  char_valid,
    output logic [5:0]            ascii_char,
    output logic                  last_char
);

    localparam int BCD_W = 4 * MAX_DIGITS;

    logic [VALUE_BITS-1:0] bin_reg;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_adj;
    logic                  ovf_reg;
    logic                  valid_reg;
    logic [5:0]            char_reg;
    logic                  last_reg;
    logic [3:0]            top_digit;

    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= b2da_pkg::BCD_FIVE)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + b2da_pkg::BCD_ADJ;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    assign top_digit     = bcd_reg[BCD_W-1 -: 4];
    assign stat.top_nz   = |top_digit;
    assign stat.overflow = ovf_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg <= value;
            bcd_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.conv_shift)
        begin
            bin_reg <= {bin_reg[VALUE_BITS-2:0], 1'b0};
            bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
            ovf_reg <= ovf_reg | bcd_adj[BCD_W-1];
        end
        else if (cmd.digit_shift)
        begin
            bcd_reg <= {bcd_reg[BCD_W-5:0], 4'd0};
        end
        if (cmd.emit)
        begin
            char_reg <= b2da_pkg::ASCII_ZERO | {2'b00, top_digit};
            last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cmd.emit;
    end

    assign char_valid = valid_reg;
    assign ascii_char = char_reg;
    assign last_char  = last_reg;

endmodule

// ===== rtl/b2da_ctrl.sv =====
// Controller: sequences load, conversion shifts and digit emission.
module b2da_ctrl #(
    parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               pad_enable,
    input  logic [3:0]         min_width,
    input  b2da_pkg::dp_stat_t stat,
    output b2da_pkg::dp_cmd_t  cmd,
    output logic               busy
);

    localparam int CNT_MAX = (VALUE_BITS > MAX_DIGITS) ? VALUE_BITS : MAX_DIGITS;
    localparam int CNT_W   = $clog2(CNT_MAX);
    localparam int CMP_W   = CNT_W + 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             seen_reg;
    logic             cnt_zero;
    logic             pad_hit;
    logic             emit_now;

    assign cnt_zero = (cnt_reg == '0);
    assign pad_hit  = pad_enable &&
                      (CMP_W'(cnt_reg) < CMP_W'(min_width));
    assign emit_now = seen_reg | stat.top_nz | stat.overflow | cnt_zero | pad_hit;
    assign busy     = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_CONV:
            begin
                cmd.conv_shift = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.digit_shift = 1'b1;
                cmd.emit        = emit_now;
                cmd.last        = cnt_zero;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_CONV;
                        cnt_reg   <= CNT_W'(VALUE_BITS - 1);
                        seen_reg  <= 1'b0;
                    end
                end
                ST_CONV:
                begin
                    if (cnt_zero)
                    begin
                        state_reg <= ST_EMIT;
                        cnt_reg   <= CNT_W'(MAX_DIGITS - 1);
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    seen_reg <= seen_reg | emit_now;
                    if (cnt_zero)
                        state_reg <= ST_IDLE;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_start_enters_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start) |=> (state_reg == ST_CONV))
        else $error("accepted request did not start conversion");

    a_emit_only_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (state_reg == ST_EMIT))
        else $error("character emitted outside emit phase");

    a_no_gap_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && seen_reg) |-> cmd.emit)
        else $error("gap in character stream");

    a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> (state_reg == ST_IDLE))
        else $error("last character did not end the request");

    a_last_always_sent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && cnt_zero) |-> (cmd.emit && cmd.last))
        else $error("request ended without a last character");

endmodule

// ===== rtl/binary_to_decimal_ascii_core.sv =====
// Top level of the binary to decimal ASCII converter.
//
// Usage:
//   Request channel: drive value and raise start; the request is taken at a
//   rising edge where start is high and busy is low.
//   Result channel: one character per cycle marked by char_valid, carrying
//   ascii_char ('0'..'9', most significant digit first) and last_char on the
//   final digit. The receiver must take every character; there is no stall.
//   Config port: cfg_we, cfg_addr, cfg_wdata. Index 0 is pad_enable (bit 0),
//   index 1 is min_width (4 bits). Write only while busy is low.
//   Sequence: double-dabble shifting of all VALUE_BITS input bits, with every
//   BCD digit adjusted in parallel, then a walk over the MAX_DIGITS BCD digits
//   from the top, one digit per cycle; leading zeros are skipped without a
//   strobe, except the lowest min_width digits when pad_enable is set. A new
//   request is taken only once busy is low again, after the final digit.
//   Reset: busy low, no strobe, pad_enable = 1, min_width = 6.
module binary_to_decimal_ascii_core #(
    parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [VALUE_BITS-1:0]           value,
    output logic                            char_valid,
    output logic [5:0]                      ascii_char,
    output logic                            last_char,
    input  logic                            cfg_we,
    input  logic [b2da_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [b2da_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic               pad_enable_reg;
    logic [3:0]         min_width_reg;
    b2da_pkg::dp_cmd_t  cmd;
    b2da_pkg::dp_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_enable_reg <= b2da_pkg::PAD_ENABLE_RST;
            min_width_reg  <= b2da_pkg::MIN_WIDTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                b2da_pkg::REG_PAD_ENABLE: pad_enable_reg <= cfg_wdata[0];
                b2da_pkg::REG_MIN_WIDTH:  min_width_reg  <= cfg_wdata[3:0];
                default:                  pad_enable_reg <= pad_enable_reg;
            endcase
        end
    end

    b2da_ctrl #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .pad_enable (pad_enable_reg),
        .min_width  (min_width_reg),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy)
    );

    b2da_dp #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .cmd        (cmd),
        .stat       (stat),
        .char_valid (char_valid),
        .ascii_char (ascii_char),
        .last_char  (last_char)
    );

endmodule

// ===== test/tb_top.sv =====
// Testbench for the binary to decimal ASCII converter: requests, register writes and digit checks.
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 250000;
    localparam int CFG_DW      = b2da_pkg::CFG_DATA_W;

    class char_scoreboard;

        typedef struct packed {
            logic [5:0] code;
            logic       last;
        } digit_char_t;

        digit_char_t pending_chars[$];
        logic        pad_en;
        logic [3:0]  min_digits;
        int          errors;

        function new();
            pad_en     = b2da_pkg::PAD_ENABLE_RST;
            min_digits = b2da_pkg::MIN_WIDTH_RST;
            errors     = 0;
        endfunction

        function void write_reg(logic [b2da_pkg::CFG_ADDR_W-1:0] addr,
                                logic [b2da_pkg::CFG_DATA_W-1:0] data);
            if (addr == b2da_pkg::REG_PAD_ENABLE)
            begin
                pad_en = data[0];
            end
            else if (addr == b2da_pkg::REG_MIN_WIDTH)
            begin
                min_digits = data;
            end
        endfunction

        function void note_request(logic [31:0] number);
            logic [3:0]  digits [b2da_pkg::MAX_DIGITS_DEF];
            logic [31:0] rest;
            int          len;
            int          width;
            int          count;
            digit_char_t c;
            foreach (digits[i])
            begin
                digits[i] = 4'd0;
            end
            rest = number;
            len  = 0;
            do
            begin
                digits[len] = 4'(rest % 10);
                rest        = rest / 10;
                len++;
            end
            while (rest != 0 && len < b2da_pkg::MAX_DIGITS_DEF);
            width = int'(min_digits);
            if (width < 1)
            begin
                width = 1;
            end
            if (width > b2da_pkg::MAX_DIGITS_DEF)
            begin
                width = b2da_pkg::MAX_DIGITS_DEF;
            end
            count = len;
            if (pad_en && width > count)
            begin
                count = width;
            end
            for (int k = 0; k < count; k++)
            begin
                c.code = b2da_pkg::ASCII_ZERO + {2'b00, digits[count - 1 - k]};
                c.last = (k == count - 1);
                pending_chars.push_back(c);
            end
        endfunction

        function void check_char(logic [5:0] code, logic last);
            digit_char_t exp_char;
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected char: ascii_char=%0d last_char=%0b",
                         $time, code, last);
                errors++;
                return;
            end
            exp_char = pending_chars.pop_front();
            if (code !== exp_char.code)
            begin
                $display("%0t: ascii_char mismatch: expected %0d, actual %0d",
                         $time, exp_char.code, code);
                errors++;
            end
            if (last !== exp_char.last)
            begin
                $display("%0t: last_char mismatch: expected %0b, actual %0b",
                         $time, exp_char.last, last);
                errors++;
            end
        endfunction

    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic [31:0]                     value;
    logic                            char_valid;
    logic [5:0]                      ascii_char;
    logic                            last_char;
    logic                            cfg_we;
    logic [b2da_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [b2da_pkg::CFG_DATA_W-1:0] cfg_wdata;

    char_scoreboard sb;
    int             cycles;

    binary_to_decimal_ascii_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .char_valid (char_valid),
        .ascii_char (ascii_char),
        .last_char  (last_char),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && char_valid)
        begin
            sb.check_char(ascii_char, last_char);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic int pick_gap(input bit bursty);
        int r;
        r = $urandom_range(0, 99);
        if (bursty || r < 45)
        begin
            return 0;
        end
        if (r < 70)
        begin
            return $urandom_range(1, 5);
        end
        if (r < 92)
        begin
            return $urandom_range(30, 50);
        end
        return $urandom_range(51, 80);
    endfunction

    function automatic logic [31:0] pick_value();
        int                r;
        int                ndig;
        longint unsigned   lo;
        longint unsigned   hi;
        longint unsigned   pow;
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            ndig = $urandom_range(1, 10);
            pow  = 1;
            for (int i = 1; i < ndig; i++)
            begin
                pow = pow * 10;
            end
            lo = (ndig == 1) ? 0 : pow;
            hi = (ndig == 10) ? 64'hFFFF_FFFF : pow * 10 - 1;
            return $urandom_range(32'(hi), 32'(lo));
        end
        if (r < 8)
        begin
            return $urandom;
        end
        if (r < 9)
        begin
            ndig = $urandom_range(0, 9);
            pow  = 1;
            for (int i = 0; i < ndig; i++)
            begin
                pow = pow * 10;
            end
            case ($urandom_range(0, 3))
                0: return 32'(pow);
                1: return 32'(pow - 1);
                2: return 32'hFFFF_FFFF;
                default: return 32'd0;
            endcase
        end
        return $urandom_range(0, 20);
    endfunction

    task automatic send_request(input logic [31:0] number, input int gap);
        @(negedge clk);
        start = 1'b1;
        value = number;
        while (busy)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        sb.note_request(number);
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            value = $urandom;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending_chars.size() != 0 || busy)
        begin
            @(negedge clk);
        end
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [b2da_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [b2da_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        @(posedge clk);
        sb.write_reg(addr, data);
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_wdata = CFG_DW'($urandom);
    endtask

    task automatic run_phase(input int count);
        bit bursty;
        bursty = ($urandom_range(0, 3) == 0);
        wait_drained();
        write_reg(b2da_pkg::REG_PAD_ENABLE, {3'($urandom), 1'($urandom)});
        write_reg(b2da_pkg::REG_MIN_WIDTH, CFG_DW'($urandom_range(0, 15)));
        repeat (count) send_request(pick_value(), pick_gap(bursty));
    endtask

    initial
    begin
        sb        = new();
        cycles    = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        value     = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: padded to six digits
        send_request(32'd0, pick_gap(0));
        send_request(32'd9, 0);
        send_request(32'd10, pick_gap(0));
        send_request(32'd999999, 0);
        send_request(32'd1000000, pick_gap(0));
        send_request(32'hFFFF_FFFF, pick_gap(0));
        send_request(32'h8000_0000, 0);

        // plain mode, upper write bits set
        wait_drained();
        write_reg(b2da_pkg::REG_PAD_ENABLE, 4'b1110);
        send_request(32'd0, pick_gap(0));
        send_request(32'd1, 0);
        send_request(32'd1000000000, pick_gap(0));
        send_request(32'hFFFF_FFFF, 0);
        send_request(32'd5, pick_gap(0));

        // padded with a zero width, then an oversized, the full and a one-digit width
        wait_drained();
        write_reg(b2da_pkg::REG_PAD_ENABLE, 4'b0001);
        write_reg(b2da_pkg::REG_MIN_WIDTH, 4'd0);
        send_request(32'd0, 0);
        send_request(32'd77, pick_gap(0));
        wait_drained();
        write_reg(b2da_pkg::REG_MIN_WIDTH, 4'd15);
        send_request(32'd0, pick_gap(0));
        send_request(32'hFFFF_FFFF, 0);
        wait_drained();
        write_reg(b2da_pkg::REG_MIN_WIDTH, 4'd10);
        send_request(32'd123, pick_gap(0));
        wait_drained();
        write_reg(b2da_pkg::REG_MIN_WIDTH, 4'd1);
        send_request(32'd0, 0);
        send_request(32'd8, pick_gap(0));

        repeat (8) run_phase(44);

        wait_drained();
        repeat (b2da_pkg::VALUE_BITS_DEF + b2da_pkg::MAX_DIGITS_DEF + 4) @(posedge clk);
        if (sb.errors == 0 && sb.pending_chars.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
